>>> design/mrld_pkg.sv
// types, codes and helpers shared by the marker run-length layer decoder
package mrld_pkg;

    localparam int OUT_LANES  = 4;
    localparam int HDR_LEN    = 12;
    localparam int CMD_DEPTH  = 4;
    localparam int RUN_MAX    = 256;
    localparam int LEN_W      = $clog2(RUN_MAX + 1);
    localparam int CNT_W      = 21;
    localparam int METHOD_MAX = 30;
    localparam int METHOD_RLE = 4;

    localparam logic [15:0] SIZE_HI_MAX   = 16'h000f;
    localparam logic [15:0] RESERVED_MASK = 16'h7f00;
    localparam logic [15:0] METHOD_MASK   = 16'h003f;
    localparam logic [CNT_W-1:0] CNT_SAT  = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_MARKER,
        PH_DATA,
        PH_ESC,
        PH_COUNT
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK            = 4'd0,
        ST_HDR_SHORT     = 4'd1,
        ST_SIZE_HIGH     = 4'd2,
        ST_XOR           = 4'd3,
        ST_RESERVED      = 4'd4,
        ST_METHOD_RANGE  = 4'd5,
        ST_UNSUPPORTED   = 4'd6,
        ST_EMPTY         = 4'd7,
        ST_NO_VALUE      = 4'd8,
        ST_NO_COUNT      = 4'd9,
        ST_SIZE_MISMATCH = 4'd10
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_layer;
    } t_in_item;

    typedef struct packed {
        logic [7:0] lane0;
        logic [7:0] lane1;
        logic [7:0] lane2;
        logic [7:0] lane3;
        logic [2:0] lane_count;
        logic       layer_done;
        logic [3:0] status;
        logic       inner_layer;
    } t_out_item;

    // one decoded chunk: len copies of value, optionally closing the layer
    typedef struct packed {
        logic [7:0]       value;
        logic [LEN_W-1:0] len;
        logic             done;
        t_status          status;
        logic             inner_layer;
    } t_cmd;

    function automatic t_status hdr_status(input logic [31:0] size,
                                           input logic [15:0] xsum,
                                           input logic [15:0] flags);
        logic [15:0] method;
        method = flags & METHOD_MASK;
        if (size[31:16] > SIZE_HI_MAX)
            return ST_SIZE_HIGH;
        else if (xsum != 16'd0)
            return ST_XOR;
        else if ((flags & RESERVED_MASK) != 16'd0)
            return ST_RESERVED;
        else if (method < 16'd1 || method > 16'(METHOD_MAX))
            return ST_METHOD_RANGE;
        else if (method != 16'(METHOD_RLE))
            return ST_UNSUPPORTED;
        return ST_OK;
    endfunction

endpackage

>>> design/mrld_front.sv
// front end: header check, escape parsing, decoded-length tracking
module mrld_front import mrld_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_cmd_push,
    output t_cmd     o_cmd
);

    t_phase           r_phase, n_phase;
    logic [3:0]       r_hidx, n_hidx;
    logic [7:0]       r_partial, n_partial;
    logic [15:0]      r_xor, n_xor;
    logic [31:0]      r_size, n_size;
    logic [15:0]      r_flags, n_flags;
    logic [7:0]       r_marker, n_marker;
    logic [7:0]       r_run, n_run;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_drain, n_drain;

    logic [LEN_W-1:0] len;
    logic [7:0]       value;
    logic             done;
    t_status          st;
    t_status          hs;
    logic             hdr_full;
    logic [15:0]      word;
    logic [CNT_W:0]   sum;
    logic [7:0]       b;
    logic             e;

    assign b = i_item.data_byte;
    assign e = i_item.end_of_layer;

    always_comb begin
        n_phase   = r_phase;
        n_hidx    = r_hidx;
        n_partial = r_partial;
        n_xor     = r_xor;
        n_size    = r_size;
        n_flags   = r_flags;
        n_marker  = r_marker;
        n_run     = r_run;
        n_cnt     = r_cnt;
        n_drain   = r_drain;
        len       = '0;
        value     = b;
        done      = 1'b0;
        st        = ST_OK;
        hs        = ST_OK;
        hdr_full  = (r_phase != PH_HEADER) || r_drain;
        word      = {r_partial, b};
        sum       = '0;
        if (r_drain) begin
            if (e) begin
                done = 1'b1;
                st   = hdr_status(r_size, r_xor, r_flags);
            end
        end else if (r_phase == PH_HEADER) begin
            if (!r_hidx[0]) begin
                n_partial = b;
            end else begin
                if (r_hidx[3:1] == 3'd0) n_size[31:16] = word;
                if (r_hidx[3:1] == 3'd1) n_size[15:0]  = word;
                if (r_hidx[3:1] == 3'd4) n_flags       = word;
                n_xor = r_xor ^ word;
            end
            if (r_hidx >= 4'(HDR_LEN - 1)) begin
                hs       = hdr_status(n_size, n_xor, n_flags);
                hdr_full = 1'b1;
                if (hs != ST_OK) begin
                    if (e) begin
                        done = 1'b1;
                        st   = hs;
                    end else begin
                        n_drain = 1'b1;
                    end
                end else begin
                    n_phase = PH_MARKER;
                    if (e) begin
                        done = 1'b1;
                        st   = ST_EMPTY;
                    end
                end
            end else begin
                n_hidx = r_hidx + 4'd1;
                if (e) begin
                    done = 1'b1;
                    st   = ST_HDR_SHORT;
                end
            end
        end else begin
            unique case (r_phase)
                PH_MARKER: begin
                    n_marker = b;
                    n_phase  = PH_DATA;
                end
                PH_DATA: begin
                    if (b == r_marker) n_phase = PH_ESC;
                    else               len     = LEN_W'(1);
                end
                PH_ESC: begin
                    if (b == r_marker) begin
                        len     = LEN_W'(1);
                        n_phase = PH_DATA;
                    end else begin
                        n_run   = b;
                        n_phase = PH_COUNT;
                    end
                end
                default: begin
                    len     = (b == 8'd0) ? LEN_W'(RUN_MAX) : LEN_W'(b);
                    value   = r_run;
                    n_phase = PH_DATA;
                end
            endcase
            sum   = {1'b0, r_cnt} + (CNT_W + 1)'(len);
            n_cnt = sum[CNT_W] ? CNT_SAT : sum[CNT_W-1:0];
            if (e) begin
                done = 1'b1;
                if (n_phase == PH_ESC)
                    st = ST_NO_VALUE;
                else if (n_phase == PH_COUNT)
                    st = ST_NO_COUNT;
                else if (32'(n_cnt) != r_size)
                    st = ST_SIZE_MISMATCH;
                else
                    st = ST_OK;
            end
        end
    end

    assign o_cmd_push        = i_accept && ((len != '0) || done);
    assign o_cmd.value       = value;
    assign o_cmd.len         = len;
    assign o_cmd.done        = done;
    assign o_cmd.status      = st;
    assign o_cmd.inner_layer = hdr_full & n_flags[15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && done)) begin
            r_phase   <= PH_HEADER;
            r_hidx    <= '0;
            r_partial <= '0;
            r_xor     <= '0;
            r_size    <= '0;
            r_flags   <= '0;
            r_marker  <= '0;
            r_run     <= '0;
            r_cnt     <= '0;
            r_drain   <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hidx    <= n_hidx;
            r_partial <= n_partial;
            r_xor     <= n_xor;
            r_size    <= n_size;
            r_flags   <= n_flags;
            r_marker  <= n_marker;
            r_run     <= n_run;
            r_cnt     <= n_cnt;
            r_drain   <= n_drain;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_phase == PH_HEADER && r_hidx == 4'(HDR_LEN - 1)))
        else $error("drain outside finished header");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEADER) |-> (hdr_status(r_size, r_xor, r_flags) == ST_OK))
        else $error("payload phase with bad header");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_cnt == '0))
        else $error("bytes counted during header");

endmodule

>>> design/mrld_cmd_fifo.sv
// small command queue between front and back end
module mrld_cmd_fifo import mrld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(CMD_DEPTH);

    t_cmd             r_slot [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_fill;
    logic             do_push, do_pop;

    assign o_full  = (r_fill == (PTR_W + 1)'(CMD_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + PTR_W'(1);
            if (do_pop)  r_rd <= r_rd + PTR_W'(1);
            r_fill <= r_fill + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (PTR_W + 1)'(CMD_DEPTH))
        else $error("queue overfilled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_wr == r_rd))
        else $error("empty queue with pointers apart");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_fill == $past(r_fill) + (PTR_W + 1)'(1)))
        else $error("fill count missed a push");

endmodule

>>> design/mrld_back.sv
// back end: expands commands into four-lane result items
module mrld_back import mrld_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_pop
);

    logic [LEN_W-1:0] r_sent;
    logic             r_valid;
    t_out_item        r_item;

    logic [LEN_W-1:0] rem;
    logic             last;
    logic [2:0]       count;
    logic             fire;
    t_out_item        beat;

    assign rem   = i_cmd.len - r_sent;
    assign last  = (rem <= LEN_W'(OUT_LANES));
    assign count = last ? rem[2:0] : 3'(OUT_LANES);
    assign fire  = i_cmd_valid && (!r_valid || i_pop);

    always_comb begin
        beat             = '0;
        beat.lane0       = (count > 3'd0) ? i_cmd.value : 8'd0;
        beat.lane1       = (count > 3'd1) ? i_cmd.value : 8'd0;
        beat.lane2       = (count > 3'd2) ? i_cmd.value : 8'd0;
        beat.lane3       = (count > 3'd3) ? i_cmd.value : 8'd0;
        beat.lane_count  = count;
        beat.layer_done  = last && i_cmd.done;
        beat.status      = (last && i_cmd.done) ? i_cmd.status : ST_OK;
        beat.inner_layer = last && i_cmd.done && i_cmd.inner_layer;
    end

    assign o_cmd_pop = fire && last;
    assign o_valid   = r_valid;
    assign o_item    = r_item;

    always_ff @(posedge i_clk) begin
        if (fire) r_item <= beat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= '0;
        end else begin
            if (fire)
                r_valid <= 1'b1;
            else if (i_pop)
                r_valid <= 1'b0;
            if (fire) r_sent <= last ? '0 : r_sent + LEN_W'(OUT_LANES);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_item.lane_count <= 3'(OUT_LANES)))
        else $error("too many lanes");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_item.layer_done) |-> (r_item.status == ST_OK && !r_item.inner_layer))
        else $error("status on a non-final item");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.lane_count == 3'd0) |-> r_item.layer_done)
        else $error("empty item without status");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && r_sent != '0) |-> (r_sent < i_cmd.len))
        else $error("run offset past its length");

endmodule

>>> design/marker_rle_layer_decoder_unit.sv
// top level of the escape-marker run-length layer decoder
// Decodes layers one after another: a 12-byte header is checked, then escape-coded
// payload bytes expand into result items of up to four bytes each, and the
// last item of a layer carries layer_done, status and inner_layer. The front
// end takes one input item per cycle as long as its 4-entry command queue has
// room; the back end emits one result item per cycle while the receiver pops,
// so a run of n bytes yields ceil(n/4) result items (up to 64) and holds off
// input once the queue fills. Each command passes through a queue slot before
// the back end expands it into its registered result item.
module marker_rle_layer_decoder_unit import mrld_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_full;
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd_head;
    logic out_valid;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;
    assign empty  = !out_valid;

    mrld_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    mrld_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_head)
    );

    mrld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (out_valid),
        .o_item      (o_item),
        .i_pop       (pop)
    );

endmodule

>>> sim/testbench.sv
// self-checking testbench for the marker run-length layer decoder
module testbench import mrld_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        LK_GOOD,
        LK_SHORT,
        LK_SIZE_HIGH,
        LK_XOR,
        LK_RESERVED,
        LK_METHOD_RANGE,
        LK_UNSUPPORTED,
        LK_EMPTY,
        LK_NO_VALUE,
        LK_NO_COUNT,
        LK_MISMATCH,
        LK_NOISE
    } t_layer_kind;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_item;

    t_in_item  byte_stream_q[$];
    t_out_item predicted_beats[$];
    logic [7:0] payload_bytes[$];
    logic [7:0] layer_bytes[$];

    // decoder state mirror
    t_phase      ph = PH_HEADER;
    logic [3:0]  hdr_idx = '0;
    logic [7:0]  hi_byte = '0;
    logic [15:0] xsum = '0;
    logic [31:0] size_w = '0;
    logic [15:0] flags_w = '0;
    logic [7:0]  marker = '0;
    logic [7:0]  run_val = '0;
    logic [CNT_W-1:0] dec_cnt = '0;
    logic        draining = 1'b0;

    int  mismatches = 0;
    int  results_seen = 0;
    int  send_gap = 0;
    int  pop_gap = 0;
    logic hold_off = 1'b0;
    t_out_item want;

    marker_rle_layer_decoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic clear_decoder();
        ph = PH_HEADER;
        hdr_idx = '0;
        hi_byte = '0;
        xsum = '0;
        size_w = '0;
        flags_w = '0;
        marker = '0;
        run_val = '0;
        dec_cnt = '0;
        draining = 1'b0;
    endtask

    function automatic t_status header_verdict();
        logic [5:0] method;
        method = flags_w[5:0];
        if (size_w[31:16] > SIZE_HI_MAX)
            return ST_SIZE_HIGH;
        if (xsum != 16'd0)
            return ST_XOR;
        if ((flags_w & RESERVED_MASK) != 16'd0)
            return ST_RESERVED;
        if (method == 6'd0 || method > 6'(METHOD_MAX))
            return ST_METHOD_RANGE;
        if (method != 6'(METHOD_RLE))
            return ST_UNSUPPORTED;
        return ST_OK;
    endfunction

    task automatic decode_byte(input t_in_item it);
        logic [7:0]  b;
        logic        eol;
        logic [7:0]  run_buf[RUN_MAX];
        int          nb;
        int          nres;
        int          cnt;
        int          k;
        logic        done;
        logic        hdr_full;
        t_status     st;
        logic [15:0] w;
        logic [31:0] sum;
        t_out_item   r;
        t_out_item   beats[$];
        b = it.data_byte;
        eol = it.end_of_layer;
        nb = 0;
        done = 1'b0;
        st = ST_OK;
        hdr_full = (ph != PH_HEADER) || draining;
        if (draining) begin
            if (!eol)
                return;
            done = 1'b1;
            st = header_verdict();
        end else if (ph == PH_HEADER) begin
            if (!hdr_idx[0]) begin
                hi_byte = b;
            end else begin
                w = {hi_byte, b};
                case (hdr_idx[3:1])
                    3'd0: size_w[31:16] = w;
                    3'd1: size_w[15:0] = w;
                    3'd4: flags_w = w;
                    default: ;
                endcase
                xsum = xsum ^ w;
            end
            if (hdr_idx >= 4'(HDR_LEN - 1)) begin
                hdr_full = 1'b1;
                st = header_verdict();
                if (st != ST_OK) begin
                    if (eol)
                        done = 1'b1;
                    else
                        draining = 1'b1;
                end else begin
                    ph = PH_MARKER;
                    if (eol) begin
                        done = 1'b1;
                        st = ST_EMPTY;
                    end
                end
            end else begin
                hdr_idx = hdr_idx + 4'd1;
                if (eol) begin
                    done = 1'b1;
                    st = ST_HDR_SHORT;
                end
            end
        end else begin
            case (ph)
                PH_MARKER: begin
                    marker = b;
                    ph = PH_DATA;
                end
                PH_DATA: begin
                    if (b == marker) begin
                        ph = PH_ESC;
                    end else begin
                        run_buf[0] = b;
                        nb = 1;
                    end
                end
                PH_ESC: begin
                    if (b == marker) begin
                        run_buf[0] = marker;
                        nb = 1;
                        ph = PH_DATA;
                    end else begin
                        run_val = b;
                        ph = PH_COUNT;
                    end
                end
                default: begin
                    nb = (b == 8'd0) ? RUN_MAX : int'(b);
                    for (k = 0; k < nb; k++)
                        run_buf[k] = run_val;
                    ph = PH_DATA;
                end
            endcase
            sum = 32'(dec_cnt) + 32'(nb);
            dec_cnt = (sum > 32'(CNT_SAT)) ? CNT_SAT : sum[CNT_W-1:0];
            if (eol) begin
                done = 1'b1;
                if (ph == PH_ESC)
                    st = ST_NO_VALUE;
                else if (ph == PH_COUNT)
                    st = ST_NO_COUNT;
                else
                    st = (32'(dec_cnt) != size_w) ? ST_SIZE_MISMATCH : ST_OK;
            end
        end

        nres = (nb + OUT_LANES - 1) / OUT_LANES;
        for (k = 0; k < nres; k++) begin
            r = '0;
            cnt = nb - k * OUT_LANES;
            if (cnt > OUT_LANES)
                cnt = OUT_LANES;
            if (cnt > 0) r.lane0 = run_buf[k * OUT_LANES];
            if (cnt > 1) r.lane1 = run_buf[k * OUT_LANES + 1];
            if (cnt > 2) r.lane2 = run_buf[k * OUT_LANES + 2];
            if (cnt > 3) r.lane3 = run_buf[k * OUT_LANES + 3];
            r.lane_count = 3'(cnt);
            beats = {beats, r};
        end
        if (done) begin
            if (beats.size() == 0) begin
                r = '0;
                beats = {beats, r};
            end
            r = beats.pop_back();
            r.layer_done = 1'b1;
            r.status = st;
            r.inner_layer = hdr_full ? flags_w[15] : 1'b0;
            beats = {beats, r};
            clear_decoder();
        end
        for (k = 0; k < beats.size(); k++)
            predicted_beats = {predicted_beats, beats[k]};
    endtask

    // moves layer_bytes into the input stream, end of layer on the last one
    task automatic push_bytes();
        t_in_item it;
        int i;
        for (i = 0; i < layer_bytes.size(); i++) begin
            it.data_byte = layer_bytes[i];
            it.end_of_layer = (i == layer_bytes.size() - 1);
            byte_stream_q = {byte_stream_q, it};
        end
        layer_bytes.delete();
    endtask

    task automatic add_layer(input t_layer_kind kind);
        logic [7:0]  mark;
        logic [7:0]  v;
        logic [15:0] w[6];
        logic [31:0] size;
        int ntok, dlen, cnt, i, nextra;
        logic coin;
        payload_bytes.delete();
        mark = 8'($urandom);
        dlen = 0;
        ntok = $urandom_range(0, 6);
        coin = 1'($urandom);
        payload_bytes = {payload_bytes, mark};
        for (i = 0; i < ntok; i++) begin
            v = 8'($urandom);
            if (v == mark)
                v = v + 8'd1;
            case ($urandom_range(0, 3))
                0, 1: begin
                    payload_bytes = {payload_bytes, v};
                    dlen++;
                end
                2: begin
                    payload_bytes = {payload_bytes, mark, mark};
                    dlen++;
                end
                default: begin
                    if ($urandom_range(0, 15) == 0)
                        cnt = $urandom_range(0, 255);
                    else
                        cnt = $urandom_range(1, 12);
                    payload_bytes = {payload_bytes, mark, v, 8'(cnt)};
                    dlen += (cnt == 0) ? RUN_MAX : cnt;
                end
            endcase
        end
        if (kind == LK_NO_VALUE)
            payload_bytes = {payload_bytes, mark};
        if (kind == LK_NO_COUNT) begin
            v = 8'($urandom);
            if (v == mark)
                v = v + 8'd1;
            payload_bytes = {payload_bytes, mark, v};
        end

        size = 32'(dlen);
        if (kind == LK_MISMATCH)
            size = size ^ (32'd1 << $urandom_range(0, 19));
        w[0] = size[31:16];
        w[1] = size[15:0];
        w[2] = 16'($urandom);
        w[3] = 16'($urandom);
        w[4] = 16'(METHOD_RLE);
        w[4][15] = 1'($urandom);
        w[4][7:6] = 2'($urandom);
        if (kind == LK_SIZE_HIGH) begin
            w[0] = 16'($urandom_range(16, 65535));
            if (coin)
                w[4][14:8] = 7'($urandom_range(1, 127));
        end
        if (kind == LK_RESERVED)
            w[4][14:8] = 7'($urandom_range(1, 127));
        if (coin && (kind == LK_SIZE_HIGH || kind == LK_XOR || kind == LK_RESERVED))
            w[4][5:0] = $urandom_range(0, 1) ? 6'd0 : 6'd12;
        if (kind == LK_METHOD_RANGE)
            w[4][5:0] = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(31, 63));
        if (kind == LK_UNSUPPORTED) begin
            cnt = $urandom_range(1, 29);
            if (cnt >= METHOD_RLE)
                cnt++;
            if ($urandom_range(0, 2) == 0)
                cnt = 12;
            w[4][5:0] = 6'(cnt);
        end
        w[5] = w[0] ^ w[1] ^ w[2] ^ w[3] ^ w[4];
        if (kind == LK_XOR || (kind == LK_SIZE_HIGH && coin))
            w[5] = w[5] ^ 16'($urandom_range(1, 65535));

        layer_bytes.delete();
        for (i = 0; i < 6; i++)
            layer_bytes = {layer_bytes, w[i][15:8], w[i][7:0]};
        case (kind)
            LK_SHORT: begin
                nextra = $urandom_range(1, HDR_LEN - 1);
                while (layer_bytes.size() > nextra)
                    void'(layer_bytes.pop_back());
            end
            LK_EMPTY: ;
            LK_SIZE_HIGH, LK_XOR, LK_RESERVED, LK_METHOD_RANGE, LK_UNSUPPORTED: begin
                nextra = $urandom_range(0, 4);
                for (i = 0; i < nextra; i++)
                    layer_bytes = {layer_bytes, 8'($urandom)};
            end
            LK_NOISE: begin
                layer_bytes.delete();
                nextra = $urandom_range(1, 20);
                for (i = 0; i < nextra; i++)
                    layer_bytes = {layer_bytes, 8'($urandom)};
            end
            default: begin
                for (i = 0; i < payload_bytes.size(); i++)
                    layer_bytes = {layer_bytes, payload_bytes[i]};
            end
        endcase
        push_bytes();
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (send_gap > 0) begin
            push <= 1'b0;
            send_gap = send_gap - 1;
        end else if (byte_stream_q.size() >= 40 && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            send_gap = $urandom_range(0, 2);
        end else if (byte_stream_q.size() != 0) begin
            push <= 1'b1;
            i_item <= byte_stream_q[0];
        end else begin
            push <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            decode_byte(i_item);
            void'(byte_stream_q.pop_front());
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            pop <= 1'b0;
        end else if (pop_gap > 0) begin
            pop <= 1'b0;
            pop_gap = pop_gap - 1;
        end else if (byte_stream_q.size() >= 40 && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            pop_gap = $urandom_range(0, 2);
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (predicted_beats.size() == 0) begin
                $error("result item with none expected");
                mismatches++;
            end else begin
                want = predicted_beats.pop_front();
                check_field("lane0", want.lane0, o_item.lane0);
                check_field("lane1", want.lane1, o_item.lane1);
                check_field("lane2", want.lane2, o_item.lane2);
                check_field("lane3", want.lane3, o_item.lane3);
                check_field("lane_count", want.lane_count, o_item.lane_count);
                check_field("layer_done", want.layer_done, o_item.layer_done);
                check_field("status", want.status, o_item.status);
                check_field("inner_layer", want.inner_layer, o_item.inner_layer);
            end
        end
    end

    // long receiver stall so the input side backs up
    initial begin
        while (results_seen < 20)
            @(posedge i_clk);
        hold_off = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #2000000;
        $display("** marker_rle_layer_decoder_unit: FAILED **");
        $finish;
    end

    initial begin
        int r;
        clear_decoder();
        // good layer: 0xff marker, literal zero, escaped marker, run of 256
        layer_bytes = '{8'h00, 8'h00, 8'h01, 8'h02, 8'hff, 8'hff, 8'h00, 8'h00,
                        8'h80, 8'h04, 8'h7e, 8'hf9,
                        8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h00};
        push_bytes();
        // short header
        layer_bytes = '{8'hff, 8'h00};
        push_bytes();
        while (byte_stream_q.size() < 250) begin
            r = $urandom_range(0, 19);
            if (r >= 8 && r <= 18)
                add_layer(t_layer_kind'(r - 7));
            else
                add_layer(LK_GOOD);
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_stream_q.size() != 0 || predicted_beats.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && predicted_beats.size() == 0)
            $display("** marker_rle_layer_decoder_unit: PASSED **");
        else
            $display("** marker_rle_layer_decoder_unit: FAILED **");
        $finish;
    end

endmodule
